// ===== hdl/smfp_pkg.sv =====
`timescale 1ns / 1ps

package smfp_pkg;

    // Field storage
    localparam int FIELD_LIMIT = 7;
    localparam int IDX_W       = $clog2(FIELD_LIMIT + 1);

    // Field positions inside a packet
    localparam int FLD_NODE   = 0;
    localparam int FLD_SENSOR = 1;
    localparam int FLD_MTYPE  = 2;
    localparam int FLD_ACK    = 3;
    localparam int FLD_DTYPE  = 4;
    localparam int FLD_BRIGHT = 5;
    localparam int FLD_CCT    = 6;

    // Characters
    localparam logic [7:0] CHAR_SEP = 8'h3B;   // ';'
    localparam logic [7:0] CHAR_0   = 8'h30;   // '0'
    localparam logic [7:0] CHAR_9   = 8'h39;   // '9'

    // Number limits
    localparam logic [15:0] ACC_MAX    = 16'hFFFF;
    localparam logic [15:0] MTYPE_SET  = 16'd1;
    localparam logic [15:0] CCT_HIGH   = 16'd6500;
    localparam logic [15:0] CCT_LOW    = 16'd2700;
    localparam logic [6:0]  BRIGHT_MAX = 7'd100;
    localparam logic [9:0]  DUTY_FULL  = 10'd1000;
    localparam int          CCT_SCOPE  = 38;

    // Division by 38 as multiply and shift; exact for dividends up to 38000
    localparam int          DIV38_SHIFT = 21;
    localparam logic [31:0] DIV38_MUL   =
        32'(((2 ** DIV38_SHIFT) + CCT_SCOPE - 1) / CCT_SCOPE);

    // Division by 1000 as multiply and shift; exact for dividends up to 100000
    localparam int          DIV1K_SHIFT = 27;
    localparam logic [34:0] DIV1K_MUL   = 35'(((2 ** DIV1K_SHIFT) + 999) / 1000);

    // Configuration register reset values
    localparam logic [7:0] LIGHT_RST    = 8'd27;
    localparam logic [7:0] SOUND_RST    = 8'd33;
    localparam logic [7:0] TEMP_RST     = 8'd6;
    localparam logic [7:0] HUMIDITY_RST = 8'd7;
    localparam logic [7:0] DIMMER_RST   = 8'd4;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT    = 3'd0,
        CFG_SOUND    = 3'd1,
        CFG_TEMP     = 3'd2,
        CFG_HUMIDITY = 3'd3,
        CFG_DIMMER   = 3'd4
    } cfg_index_t;

    typedef logic [15:0] word_t;
    typedef word_t [FIELD_LIMIT-1:0] field_arr_t;

    typedef struct packed {
        logic [7:0] light;
        logic [7:0] sound;
        logic [7:0] temp;
        logic [7:0] humidity;
        logic [7:0] dimmer;
    } type_codes_t;

    // Result fields that ride along the math pipeline
    typedef struct packed {
        word_t node_id;
        word_t sensor_id;
        word_t msg_kind;
        word_t ack_flag;
        word_t dev_kind;
        word_t sensor_value;
        logic  value_valid;
        logic  light_update;
    } hdr_t;

endpackage

// ===== hdl/sensor_message_field_parser.sv =====
`timescale 1ns / 1ps

// Throughput: one byte per cycle, except while an end-of-packet byte waits for a held
// snapshot. The input register, the packet snapshot and four math stages (decode, two
// reciprocal multiplies, the duty products) each hold one item. Reset (rst_n, async,
// active low) restores the device type codes to 27, 33, 6, 7, 4, clears the parse
// state and the held sensor value, and empties all stages.
module sensor_message_field_parser
(
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: [7:0] text_byte
    input  logic [7:0]                        s_tdata,
    // s_tlast: end_of_packet
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: [15:0] node_id, [31:16] sensor_id, [47:32] msg_kind,
    //          [63:48] ack_flag, [79:64] dev_kind, [95:80] sensor_value,
    //          [102:96] warm_duty, [109:103] cold_duty, [111:110] zero
    output logic [111:0]                      m_tdata,
    // m_tuser: [0] value_valid, [1] light_update
    output logic [1:0]                        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);
    import smfp_pkg::*;

    type_codes_t codes_reg;
    field_arr_t  snap_fields;
    logic        snap_valid;
    logic        snap_ready;
    hdr_t        res_hdr;
    logic [6:0]  res_warm;
    logic [6:0]  res_cold;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.light    <= LIGHT_RST;
            codes_reg.sound    <= SOUND_RST;
            codes_reg.temp     <= TEMP_RST;
            codes_reg.humidity <= HUMIDITY_RST;
            codes_reg.dimmer   <= DIMMER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LIGHT:    codes_reg.light    <= cfg_data;
                CFG_SOUND:    codes_reg.sound    <= cfg_data;
                CFG_TEMP:     codes_reg.temp     <= cfg_data;
                CFG_HUMIDITY: codes_reg.humidity <= cfg_data;
                CFG_DIMMER:   codes_reg.dimmer   <= cfg_data;
                default:      ;
            endcase
        end
    end

    smfp_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .snap_fields (snap_fields),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready)
    );

    smfp_calc u_calc
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .codes       (codes_reg),
        .snap_fields (snap_fields),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .res_hdr     (res_hdr),
        .res_warm    (res_warm),
        .res_cold    (res_cold),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready)
    );

    // Result packing
    assign m_tdata = {2'b00, res_cold, res_warm, res_hdr.sensor_value,
                      res_hdr.dev_kind, res_hdr.ack_flag, res_hdr.msg_kind,
                      res_hdr.sensor_id, res_hdr.node_id};
    assign m_tuser = {res_hdr.light_update, res_hdr.value_valid};

endmodule

// ===== hdl/smfp_parse.sv =====
`timescale 1ns / 1ps

module smfp_parse
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output smfp_pkg::field_arr_t   snap_fields,
    output logic                   snap_valid,
    input  logic                   snap_ready
);
    import smfp_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eop_reg;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      acc_reg, acc_next;
    logic             ended_reg, ended_next;
    field_arr_t       fields_reg, fields_next;

    logic             snap_valid_reg;
    field_arr_t       snap_fields_reg;

    logic             advance;
    logic             fire;
    logic             is_sep;
    logic             is_digit;
    logic [19:0]      acc_sum;
    logic [15:0]      acc_after;
    logic [IDX_W-1:0] idx_after;
    field_arr_t       fields_w;
    field_arr_t       snap_w;

    // The byte in the input register moves on unless it ends a packet
    // and the snapshot register is still held
    assign advance  = !in_eop_reg || !snap_valid_reg || snap_ready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eop_reg  <= s_tlast;
        end
    end

    // One parse step for the byte in the input register
    always_comb
    begin
        is_sep   = (in_byte_reg == CHAR_SEP);
        is_digit = (in_byte_reg inside {[CHAR_0:CHAR_9]});
        acc_sum  = 20'({acc_reg, 3'b000}) + 20'({acc_reg, 1'b0})
                 + 20'(in_byte_reg - CHAR_0);

        if (is_sep)
            acc_after = '0;
        else if (is_digit && !ended_reg)
            acc_after = (acc_sum > 20'(ACC_MAX)) ? ACC_MAX : acc_sum[15:0];
        else
            acc_after = acc_reg;

        ended_next = !is_sep && (ended_reg || !is_digit);

        if (is_sep && (idx_reg < IDX_W'(FIELD_LIMIT)))
            idx_after = idx_reg + 1'b1;
        else
            idx_after = idx_reg;

        // Separator closes the current field; end of packet closes the next
        for (int i = 0; i < FIELD_LIMIT; i++)
        begin
            fields_w[i] = (is_sep && idx_reg == IDX_W'(i)) ? acc_reg : fields_reg[i];
            snap_w[i]   = (idx_after == IDX_W'(i)) ? acc_after : fields_w[i];
        end

        if (in_eop_reg)
        begin
            idx_next    = '0;
            acc_next    = '0;
            ended_next  = 1'b0;
            fields_next = '0;
        end
        else
        begin
            idx_next    = idx_after;
            acc_next    = acc_after;
            fields_next = fields_w;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            acc_reg    <= '0;
            ended_reg  <= 1'b0;
            fields_reg <= '0;
        end
        else if (fire)
        begin
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            ended_reg  <= ended_next;
            fields_reg <= fields_next;
        end
    end

    // Snapshot register: all fields of a finished packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (!snap_valid_reg || snap_ready)
        begin
            snap_valid_reg <= in_valid_reg && in_eop_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_eop_reg)
        begin
            snap_fields_reg <= snap_w;
        end
    end

    assign snap_valid  = snap_valid_reg;
    assign snap_fields = snap_fields_reg;

endmodule

// ===== hdl/smfp_calc.sv =====
`timescale 1ns / 1ps

module smfp_calc
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  smfp_pkg::type_codes_t  codes,
    input  smfp_pkg::field_arr_t   snap_fields,
    input  logic                   snap_valid,
    output logic                   snap_ready,
    output smfp_pkg::hdr_t         res_hdr,
    output logic [6:0]             res_warm,
    output logic [6:0]             res_cold,
    output logic                   res_valid,
    input  logic                   res_ready
);
    import smfp_pkg::*;

    logic        adv2, adv3, adv4, adv_out;

    logic [15:0] held_reg;

    logic        s2_valid_reg;
    hdr_t        s2_hdr_reg;
    logic [6:0]  s2_bright_reg;
    logic [15:0] s2_t_reg;

    logic        s3_valid_reg;
    hdr_t        s3_hdr_reg;
    logic [6:0]  s3_bright_reg;
    logic [9:0]  s3_w_reg;

    logic        s4_valid_reg;
    hdr_t        s4_hdr_reg;
    logic [16:0] s4_warm_p_reg;
    logic [16:0] s4_cold_p_reg;

    logic        out_valid_reg;
    hdr_t        out_hdr_reg;
    logic [6:0]  out_warm_reg;
    logic [6:0]  out_cold_reg;

    logic        is_set;
    logic        light_hit;
    logic        sens_hit;
    logic [15:0] f_dtype;
    logic [15:0] f_bright;
    logic [15:0] f_cct;
    logic [15:0] cct;
    logic [11:0] cct_ofs;
    logic [15:0] t_val;
    logic [6:0]  bright;
    hdr_t        hdr1;
    logic [31:0] w_prod;
    logic [9:0]  inv_w;
    logic [16:0] warm_p;
    logic [16:0] cold_p;
    logic [34:0] warm_q;
    logic [34:0] cold_q;

    // Stage handshakes: a stage moves when the one after it has room
    assign adv_out    = !out_valid_reg || res_ready;
    assign adv4       = !s4_valid_reg || adv_out;
    assign adv3       = !s3_valid_reg || adv4;
    assign adv2       = !s2_valid_reg || adv3;
    assign snap_ready = adv2;

    // Stage 1: decode the device type, clamp brightness and color temperature
    always_comb
    begin
        f_dtype  = snap_fields[FLD_DTYPE];
        f_bright = snap_fields[FLD_BRIGHT];
        f_cct    = snap_fields[FLD_CCT];

        is_set    = (snap_fields[FLD_MTYPE] == MTYPE_SET);
        light_hit = is_set && (f_dtype == 16'(codes.light));
        sens_hit  = is_set && !light_hit &&
                    ((f_dtype == 16'(codes.sound)) || (f_dtype == 16'(codes.temp)) ||
                     (f_dtype == 16'(codes.humidity)) || (f_dtype == 16'(codes.dimmer)));

        // Brightness of zero gives zero duties when no light is addressed
        if (!light_hit)
            bright = '0;
        else if (f_bright > 16'(BRIGHT_MAX))
            bright = BRIGHT_MAX;
        else
            bright = f_bright[6:0];

        if (f_cct > CCT_HIGH)
            cct = CCT_HIGH;
        else if (f_cct < CCT_LOW)
            cct = CCT_LOW;
        else
            cct = f_cct;

        cct_ofs = 12'(cct - CCT_LOW);
        t_val   = 16'({4'b0000, cct_ofs} << 3) + 16'({4'b0000, cct_ofs} << 1);

        hdr1.node_id      = snap_fields[FLD_NODE];
        hdr1.sensor_id    = snap_fields[FLD_SENSOR];
        hdr1.msg_kind     = snap_fields[FLD_MTYPE];
        hdr1.ack_flag     = snap_fields[FLD_ACK];
        hdr1.dev_kind     = f_dtype;
        hdr1.sensor_value = sens_hit ? f_bright : held_reg;
        hdr1.value_valid  = sens_hit;
        hdr1.light_update = light_hit;
    end

    // Held sensor value, updated in packet order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (snap_valid && adv2 && sens_hit)
        begin
            held_reg <= f_bright;
        end
    end

    // Stage 2: divide by 38 through a reciprocal multiply
    assign w_prod = 32'(s2_t_reg) * DIV38_MUL;

    // Stage 3: duty products
    assign inv_w  = DUTY_FULL - s3_w_reg;
    assign warm_p = 17'(inv_w) * 17'(s3_bright_reg);
    assign cold_p = 17'(s3_w_reg) * 17'(s3_bright_reg);

    // Stage 4: divide by 1000 through a reciprocal multiply
    assign warm_q = 35'(s4_warm_p_reg) * DIV1K_MUL;
    assign cold_q = 35'(s4_cold_p_reg) * DIV1K_MUL;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv2)
                s2_valid_reg <= snap_valid;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
            if (adv4)
                s4_valid_reg <= s3_valid_reg;
            if (adv_out)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_hdr_reg    <= hdr1;
            s2_bright_reg <= bright;
            s2_t_reg      <= t_val;
        end
        if (adv3)
        begin
            s3_hdr_reg    <= s2_hdr_reg;
            s3_bright_reg <= s2_bright_reg;
            s3_w_reg      <= w_prod[DIV38_SHIFT +: 10];
        end
        if (adv4)
        begin
            s4_hdr_reg    <= s3_hdr_reg;
            s4_warm_p_reg <= warm_p;
            s4_cold_p_reg <= cold_p;
        end
        if (adv_out)
        begin
            out_hdr_reg  <= s4_hdr_reg;
            out_warm_reg <= warm_q[DIV1K_SHIFT +: 7];
            out_cold_reg <= cold_q[DIV1K_SHIFT +: 7];
        end
    end

    assign res_valid = out_valid_reg;
    assign res_hdr   = out_hdr_reg;
    assign res_warm  = out_warm_reg;
    assign res_cold  = out_cold_reg;

endmodule
